@@ src/lesq_pkg.sv @@
// Package for the largest empty square scan.
// Holds field widths and configuration register indexes shared by the
// result channel interface and the top level. Depends on nothing.
`timescale 1ns / 1ps

package lesq_pkg;

   // Field widths of the channel beats.
   localparam int SIZE_W  = 11;
   localparam int COORD_W = 10;

   // Configuration port shape.
   localparam int CSR_DATA_W = 11;
   localparam int CSR_IDX_W  = 1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_WIDTH  = 1'b0,
      CSR_GRID_HEIGHT = 1'b1
   } csr_index_type;

endpackage

@@ src/lesq_req_if.sv @@
// Input channel of the largest empty square scan: one grid cell per beat.
// Depends on nothing.
`timescale 1ns / 1ps

interface lesq_req_if;
   logic valid;
   logic ready;
   logic cell_empty;

   modport source (output valid, output cell_empty, input ready);
   modport sink (input valid, input cell_empty, output ready);
endinterface

@@ src/lesq_rsp_if.sv @@
// Result channel of the largest empty square scan: one result per cell beat.
// Field widths come from lesq_pkg.
`timescale 1ns / 1ps

interface lesq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [lesq_pkg::SIZE_W-1:0]    square_size;
   logic [lesq_pkg::SIZE_W-1:0]    best_size;
   logic [lesq_pkg::COORD_W-1:0]   best_col;
   logic [lesq_pkg::COORD_W-1:0]   best_row;
   logic                           frame_done;

   modport source (output valid, output square_size, output best_size, output best_col,
                   output best_row, output frame_done, input ready);
   modport sink (input valid, input square_size, input best_size, input best_col,
                 input best_row, input frame_done, output ready);
endinterface

@@ src/largest_empty_square_scan.sv @@
// Largest empty square scan. Cells stream in bottom row first, right to left,
// and each cell beat yields one result beat: the size of the largest empty
// square whose top-left corner is that cell, plus the best square of the frame
// so far and a frame-done flag on the top-left cell. One cell is taken every
// cycle unless the result channel stalls; each result passes through the
// registered read of the row buffer (a one-entry-per-column RAM) and the result
// register. Writing grid_width or grid_height restarts the frame and must only
// happen while no results are outstanding. Depends on lesq_pkg, lesq_req_if,
// lesq_rsp_if and lesq_ram.
`timescale 1ns / 1ps

module largest_empty_square_scan #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                                clock,
   input  logic                                reset,
   lesq_req_if.sink                            req_chan,
   lesq_rsp_if.source                          rsp_chan,
   input  logic                                csr_wr_en,
   input  logic [lesq_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [lesq_pkg::CSR_DATA_W-1:0]     csr_wr_data
);

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int ROW_W = $clog2(MAX_HEIGHT);
   localparam int SW    = lesq_pkg::SIZE_W;

   // Grid shape, kept as the last column and last row index.
   logic [COL_W-1:0] last_col_ff;
   logic [ROW_W-1:0] last_row_ff;
   logic [COL_W-1:0] last_col_in;
   logic [ROW_W-1:0] last_row_in;

   // Position of the next cell to arrive.
   logic [COL_W-1:0] col_pos_ff, col_pos_in;
   logic [ROW_W-1:0] row_pos_ff, row_pos_in;

   // Input stage: cell and its position, row buffer read in flight.
   logic             s1_valid_ff;
   logic             s1_empty_ff;
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_first_ff;
   logic             s1_edge_ff;
   logic             s1_done_ff;
   logic             fwd_ff;
   logic [SW-1:0]    fwd_data_ff;

   // Running neighbor values and best square.
   logic [SW-1:0]    right_ff;
   logic [SW-1:0]    diag_ff;
   logic [SW-1:0]    best_size_ff, best_size_in;
   logic [COL_W-1:0] best_col_ff, best_col_in;
   logic [ROW_W-1:0] best_row_ff, best_row_in;

   // Result register.
   logic             rsp_valid_ff;
   logic [SW-1:0]    rsp_size_ff;
   logic             rsp_done_ff;

   logic             req_accept;
   logic             s1_adv;
   logic             csr_restart;
   logic [SW-1:0]    ram_rd_data;
   logic [SW-1:0]    below_val;
   logic [SW-1:0]    min_rb;
   logic [SW-1:0]    min_all;
   logic [SW-1:0]    size_in;

   // Handshake: the input stage frees up whenever it moves into the result register.
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_accept     = req_chan.valid && req_chan.ready;

   // Configuration: clamp the written dimension into 1..MAX and keep index form.
   always_comb begin
      last_col_in = last_col_ff;
      last_row_in = last_row_ff;
      csr_restart = 1'b0;
      if (csr_wr_en) begin
         case (lesq_pkg::csr_index_type'(csr_index))
            lesq_pkg::CSR_GRID_WIDTH: begin
               csr_restart = 1'b1;
               if (csr_wr_data == '0) begin
                  last_col_in = '0;
               end else if (32'(csr_wr_data) > MAX_WIDTH) begin
                  last_col_in = COL_W'(MAX_WIDTH - 1);
               end else begin
                  last_col_in = COL_W'(csr_wr_data - 1'b1);
               end
            end
            lesq_pkg::CSR_GRID_HEIGHT: begin
               csr_restart = 1'b1;
               if (csr_wr_data == '0) begin
                  last_row_in = '0;
               end else if (32'(csr_wr_data) > MAX_HEIGHT) begin
                  last_row_in = ROW_W'(MAX_HEIGHT - 1);
               end else begin
                  last_row_in = ROW_W'(csr_wr_data - 1'b1);
               end
            end
            default: begin
               csr_restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_col_ff <= '0;
         last_row_ff <= '0;
      end else begin
         last_col_ff <= last_col_in;
         last_row_ff <= last_row_in;
      end
   end

   // Next position: right to left, then up one row, wrapping at the top-left.
   always_comb begin
      if (col_pos_ff == '0) begin
         col_pos_in = last_col_ff;
         row_pos_in = (row_pos_ff == '0) ? last_row_ff : row_pos_ff - 1'b1;
      end else begin
         col_pos_in = col_pos_ff - 1'b1;
         row_pos_in = row_pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_pos_ff <= '0;
         row_pos_ff <= '0;
      end else if (csr_restart) begin
         col_pos_ff <= last_col_in;
         row_pos_ff <= last_row_in;
      end else if (req_accept) begin
         col_pos_ff <= col_pos_in;
         row_pos_ff <= row_pos_in;
      end
   end

   // Row buffer: read at the arriving cell's column, written when the cell retires.
   lesq_ram #(
      .WIDTH (SW),
      .DEPTH (MAX_WIDTH)
   ) u_row_buf (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_col_ff),
      .wr_data (size_in),
      .rd_en   (req_accept),
      .rd_addr (col_pos_ff),
      .rd_data (ram_rd_data)
   );

   // Input stage occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_adv) begin
         s1_valid_ff <= 1'b0;
      end
   end

   // A one-column grid reads the entry being written in the same cycle, so that
   // value is forwarded around the RAM.
   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_ff <= 1'b0;
      end else if (csr_restart) begin
         fwd_ff <= 1'b0;
      end else if (req_accept) begin
         fwd_ff <= s1_adv && (s1_col_ff == col_pos_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_empty_ff <= req_chan.cell_empty;
         s1_col_ff   <= col_pos_ff;
         s1_row_ff   <= row_pos_ff;
         s1_first_ff <= (col_pos_ff == last_col_ff) && (row_pos_ff == last_row_ff);
         s1_edge_ff  <= (col_pos_ff == last_col_ff) || (row_pos_ff == last_row_ff);
         s1_done_ff  <= (col_pos_ff == '0) && (row_pos_ff == '0);
         fwd_data_ff <= size_in;
      end
   end

   // Square size: 0 if full, 1 on an edge, else 1 + min(right, below, below-right).
   assign below_val = fwd_ff ? fwd_data_ff : ram_rd_data;
   assign min_rb    = (right_ff < below_val) ? right_ff : below_val;
   assign min_all   = (diag_ff < min_rb) ? diag_ff : min_rb;

   always_comb begin
      if (!s1_empty_ff) begin
         size_in = '0;
      end else if (s1_edge_ff) begin
         size_in = SW'(1);
      end else begin
         size_in = min_all + 1'b1;
      end
   end

   // Best square: the frame's first cell always takes it, ties go to later cells.
   always_comb begin
      best_size_in = best_size_ff;
      best_col_in  = best_col_ff;
      best_row_in  = best_row_ff;
      if (s1_first_ff || (s1_empty_ff && (size_in >= best_size_ff))) begin
         best_size_in = size_in;
         best_col_in  = s1_col_ff;
         best_row_in  = s1_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         right_ff     <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_col_ff  <= '0;
         best_row_ff  <= '0;
      end else if (csr_restart) begin
         right_ff     <= '0;
         diag_ff      <= '0;
         best_size_ff <= '0;
         best_col_ff  <= '0;
         best_row_ff  <= '0;
      end else if (s1_adv) begin
         right_ff     <= size_in;
         diag_ff      <= below_val;
         best_size_ff <= best_size_in;
         best_col_ff  <= best_col_in;
         best_row_ff  <= best_row_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_adv) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         rsp_size_ff <= size_in;
         rsp_done_ff <= s1_done_ff;
      end
   end

   // The best fields follow the running best, which only moves with a new beat or a restart.
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.square_size = rsp_size_ff;
   assign rsp_chan.best_size   = best_size_ff;
   assign rsp_chan.best_col    = lesq_pkg::COORD_W'(best_col_ff);
   assign rsp_chan.best_row    = lesq_pkg::COORD_W'(best_row_ff);
   assign rsp_chan.frame_done  = rsp_done_ff;

   // Forwarding around the row buffer only happens on a one-column grid.
   a_fwd_single_col: assert property (@(posedge clock) disable iff (reset)
      fwd_ff |-> (last_col_ff == '0))
      else $error("row buffer forward on a grid wider than one column");

   // The scan position never leaves the grid.
   a_pos_in_grid: assert property (@(posedge clock) disable iff (reset)
      (col_pos_ff <= last_col_ff) && (row_pos_ff <= last_row_ff))
      else $error("scan position outside the grid");

   // The best square's corner lies inside the grid.
   a_best_in_grid: assert property (@(posedge clock) disable iff (reset)
      (best_col_ff <= last_col_ff) && (best_row_ff <= last_row_ff))
      else $error("best square corner outside the grid");

endmodule

@@ src/lesq_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Used as the row buffer of the largest empty square scan; no dependencies.
`timescale 1ns / 1ps

module lesq_ram #(
   parameter int WIDTH = 11,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port; data holds while the read enable is low.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule
